// ===== rtl/core/lpf_pkg.sv =====
// Shared types and constants of the multichannel first-order low-pass core.
// Used by lpf_div, lpf_mul and multichannel_first_order_lowpass_core.
// Depends on nothing.
package lpf_pkg;

   localparam int DATA_W     = 32;   // Q16.16 sample width
   localparam int DT_W       = 16;   // time step in microseconds
   localparam int TAU_W      = 20;   // time constant in microseconds
   localparam int CH_FIELD_W = 2;    // width of the channel field
   localparam int CMD_W      = 2;
   localparam int TAU_REGS   = 4;
   localparam int CSR_IDX_W  = 2;

   localparam int ALPHA_W    = 16;   // gain in Q0.16
   localparam int DIGIT_W    = 2;    // bits handled per cycle by the serial units
   localparam int STEPS      = ALPHA_W / DIGIT_W;
   localparam int STEP_CNT_W = $clog2(STEPS);
   localparam int DIVISOR_W  = TAU_W + 1;
   localparam int REM_W      = DIVISOR_W + 1;
   localparam int DIFF_W     = DATA_W + 1;
   localparam int ACC_W      = DATA_W + 2;

   localparam logic [TAU_W-1:0] BYPASS_TAU = TAU_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_FILTER     = 2'd0,
      CMD_PRESET_ONE = 2'd1,
      CMD_PRESET_ALL = 2'd2,
      CMD_QUERY      = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIV,
      ST_MUL,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/core/lpf_div.sv =====
// Radix-4 restoring divider that forms the gain alpha = floor(dt * 2^16 / divisor).
// Two quotient bits per cycle; the caller guarantees dt < divisor.
// Depends on lpf_pkg.
module lpf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lpf_pkg::DT_W-1:0]      dividend,
   input  logic [lpf_pkg::DIVISOR_W-1:0] divisor,
   output logic                          done,
   output logic [lpf_pkg::ALPHA_W-1:0]   quotient
);
   import lpf_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_CNT_W-1:0] cnt_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [REM_W-1:0]      rem_in;
   logic [ALPHA_W-1:0]    quot_ff;
   logic [ALPHA_W-1:0]    quot_in;
   logic [DIVISOR_W-1:0]  divisor_ff;
   logic [REM_W-1:0]      trial;

   // The remainder starts as dt; each step brings in one zero bit of the dividend.
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      trial   = '0;
      for (int i = 0; i < DIGIT_W; i++) begin
         trial = {rem_in[REM_W-2:0], 1'b0};
         if (trial >= REM_W'(divisor_ff)) begin
            rem_in  = trial - REM_W'(divisor_ff);
            quot_in = {quot_in[ALPHA_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_in[ALPHA_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + STEP_CNT_W'(1);
            if (cnt_ff == STEP_CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= REM_W'(dividend);
         quot_ff    <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== rtl/core/lpf_mul.sv =====
// Serial shift-add multiplier giving floor(alpha * diff / 2^16) for signed diff.
// Alpha is consumed two bits per cycle from the low end. Depends on lpf_pkg.
module lpf_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [lpf_pkg::ALPHA_W-1:0]        alpha,
   input  logic signed [lpf_pkg::DIFF_W-1:0]  diff,
   output logic                               done,
   output logic signed [lpf_pkg::ACC_W-1:0]   product
);
   import lpf_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [STEP_CNT_W-1:0]   cnt_ff;
   logic [ALPHA_W-1:0]      alpha_ff;
   logic [ALPHA_W-1:0]      alpha_in;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W:0]   sum;

   // Halving after every partial-product add keeps the running floor exact:
   // floor((floor(u) + n) / 2) equals floor((u + n) / 2) for integer n.
   always_comb begin
      acc_in   = acc_ff;
      alpha_in = alpha_ff;
      sum      = '0;
      for (int i = 0; i < DIGIT_W; i++) begin
         sum = {acc_in[ACC_W-1], acc_in};
         if (alpha_in[0]) begin
            sum = sum + {{(ACC_W + 1 - DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff};
         end
         acc_in   = sum[ACC_W:1];
         alpha_in = {1'b0, alpha_in[ALPHA_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + STEP_CNT_W'(1);
            if (cnt_ff == STEP_CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         alpha_ff <= alpha;
         diff_ff  <= diff;
         acc_ff   <= '0;
      end else if (busy_ff) begin
         alpha_ff <= alpha_in;
         acc_ff   <= acc_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/core/multichannel_first_order_lowpass_core.sv =====
// Multichannel first-order low-pass filter: controller, channel state, tau registers.
// Instantiates lpf_div and lpf_mul; depends on lpf_pkg.
//
// Usage: one word enters on req_* (tuser holds cmd and channel, tdata holds the
// sample or preset value and the time step) and exactly one word leaves on rsp_*
// (tuser = channel, tdata = that channel's output after the word). Time constants
// are written through csr_*, which is always ready; write them only while idle.
// Words are handled one at a time. A filter word with a nonzero time step and a
// time constant above 1 us passes through decode, the two-bit-per-cycle gain
// divider, the hand-over of its quotient, the two-bit-per-cycle multiplier, the
// forming of the update and the load of the output register. Presets, queries,
// zero time steps and bypassed channels go from decode straight to that load.
// req_tready rises again the cycle after the result is loaded into the output
// register, so a new word is taken only once the last one is through. A stalled
// receiver holds the result in the output register; one more word is accepted and
// processed meanwhile, and it waits at the end until the register frees. Reset
// clears all channel outputs and time constants to zero and clears rsp_tvalid.
module multichannel_first_order_lowpass_core #(
   parameter int CHANNELS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [47:0]                      req_tdata,  // value_in[31:0], dt_us[47:32]
   input  logic [3:0]                       req_tuser,  // cmd[1:0], channel[3:2]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lpf_pkg::DATA_W-1:0]       rsp_tdata,  // filtered_out[31:0]
   output logic [lpf_pkg::CH_FIELD_W-1:0]   rsp_tuser,  // out_channel[1:0]
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lpf_pkg::TAU_W-1:0]        csr_data
);
   import lpf_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   state_type               state_ff;
   state_type               state_in;
   cmd_type                 cmd_ff;
   logic [CH_FIELD_W-1:0]   ch_ff;
   logic signed [DATA_W-1:0] x_ff;
   logic [DT_W-1:0]         dt_ff;
   logic [DATA_W-1:0]       res_ff;
   logic [DATA_W-1:0]       res_in;
   logic [DATA_W-1:0]       chan_out_ff [CHANNELS];
   logic [TAU_W-1:0]        tau_ff [TAU_REGS];
   logic                    rsp_valid_ff;
   logic [DATA_W-1:0]       rsp_data_ff;
   logic [CH_FIELD_W-1:0]   rsp_user_ff;

   logic                    accept;
   logic                    load_out;
   logic                    div_start;
   logic                    div_done;
   logic [ALPHA_W-1:0]      alpha;
   logic                    mul_done;
   logic signed [ACC_W-1:0] product;
   logic [CH_W-1:0]         idx;
   logic                    ch_valid;
   logic [DATA_W-1:0]       y_cur;
   logic [TAU_W-1:0]        tau_cur;
   logic signed [DIFF_W-1:0] diff;
   logic [DIVISOR_W-1:0]    divisor;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   assign idx      = CH_W'(ch_ff);
   assign ch_valid = (32'(ch_ff) < CHANNELS);
   assign y_cur    = ch_valid ? chan_out_ff[idx] : '0;
   assign tau_cur  = tau_ff[ch_ff];
   assign divisor  = DIVISOR_W'(tau_cur) + DIVISOR_W'(dt_ff);
   assign diff     = DIFF_W'(x_ff) - DIFF_W'(signed'(y_cur));

   lpf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dt_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (alpha)
   );

   lpf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (div_done),
      .alpha   (alpha),
      .diff    (diff),
      .done    (mul_done),
      .product (product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      res_in    = res_ff;
      div_start = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_FINISH;
            case (cmd_ff)
               CMD_FILTER: begin
                  if (!ch_valid) begin
                     res_in = '0;
                  end else if (dt_ff == '0) begin
                     res_in = y_cur;
                  end else if (tau_cur <= BYPASS_TAU) begin
                     res_in = x_ff;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               CMD_PRESET_ONE: res_in = ch_valid ? x_ff : '0;
               CMD_PRESET_ALL: res_in = x_ff;
               default:        res_in = y_cur;
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               // The new output lies between y and x, so 32 bits always hold it.
               res_in   = y_cur + product[DATA_W-1:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Input word and result holding registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_tuser[1:0]);
         ch_ff  <= req_tuser[3:2];
         x_ff   <= req_tdata[31:0];
         dt_ff  <= req_tdata[47:32];
      end
      res_ff <= res_in;
      if (load_out) begin
         rsp_data_ff <= res_ff;
         rsp_user_ff <= ch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAU_REGS; i++) begin
            tau_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         tau_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            chan_out_ff[i] <= '0;
         end
      end else if (load_out) begin
         case (cmd_ff)
            CMD_FILTER, CMD_PRESET_ONE: begin
               if (ch_valid) begin
                  chan_out_ff[idx] <= res_ff;
               end
            end
            CMD_PRESET_ALL: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  chan_out_ff[i] <= x_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== sim/tb_multichannel_first_order_lowpass_core.sv =====
// Testbench of multichannel_first_order_lowpass_core: directed and random words with
// random idling on both streams, predicted by a behavioral model of the filter.
// Depends on lpf_pkg and the core RTL.
module tb_multichannel_first_order_lowpass_core;
   timeunit 1ns;
   timeprecision 1ps;

   import lpf_pkg::*;

   localparam int CHANNELS        = 4;
   localparam int IDLE_LIMIT      = 2000;   // cycles without any handshake
   localparam int SETTLE_CYCLES   = 40;     // pause after the last result of a phase
   localparam int HOLD_CYCLES     = 400;    // long receiver hold-off
   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 135;
   localparam int MISMATCH_SHOWN  = 10;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TAU_CH0 = 2'd0,
      REG_TAU_CH1 = 2'd1,
      REG_TAU_CH2 = 2'd2,
      REG_TAU_CH3 = 2'd3
   } csr_reg_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [CH_FIELD_W-1:0]   channel;
      logic [DATA_W-1:0]       value;
      logic [DT_W-1:0]         dt;
   } word_type;

   typedef struct packed {
      logic [CH_FIELD_W-1:0]   channel;
      logic [DATA_W-1:0]       value;
   } result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [47:0]             req_tdata = '0;   // value_in[31:0], dt_us[47:32]
   logic [3:0]              req_tuser = '0;   // cmd[1:0], channel[3:2]
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [DATA_W-1:0]       rsp_tdata;        // filtered_out[31:0]
   logic [CH_FIELD_W-1:0]   rsp_tuser;        // out_channel[1:0]
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [TAU_W-1:0]        csr_data = '0;

   // Handshakes seen at the last rising edge, read by the falling-edge drivers.
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic csr_fire = 1'b0;

   word_type   pending_words[$];
   result_type expected_outputs[$];

   logic signed [DATA_W-1:0] chan_y [CHANNELS] = '{default: '0};
   logic [TAU_W-1:0]         tau_model [TAU_REGS] = '{default: '0};
   logic signed [DATA_W-1:0] sweep_target [CHANNELS] = '{default: '0};

   int words_queued = 0;
   int words_accepted = 0;
   int results_checked = 0;
   int fail_count = 0;
   int mismatch_count = 0;
   int filter_words = 0;
   int hold_words = 0;
   int preset_words = 0;
   int query_words = 0;
   int tau_settings = 0;
   int idle_cycles = 0;

   logic        req_idle_on = 1'b1;
   logic        rsp_idle_on = 1'b1;
   int unsigned req_wait = 0;
   int unsigned rsp_wait = 0;
   int unsigned rsp_draw;
   logic        rsp_hold = 1'b0;
   logic        pressure_arm = 1'b0;

   multichannel_first_order_lowpass_core #(
      .CHANNELS(CHANNELS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Behavioral filter: updates the channel state and returns the reported word.
   function automatic result_type lowpass_next(input word_type w);
      result_type r;
      int ch;
      logic [TAU_W-1:0] tau;
      longint gain;
      longint scaled;
      ch = int'(w.channel);
      tau = tau_model[ch];
      case (w.cmd)
         CMD_FILTER: begin
            if (w.dt != '0) begin
               if (tau <= BYPASS_TAU) begin
                  chan_y[ch] = w.value;
               end else begin
                  gain = (longint'(w.dt) << 16) / (longint'(tau) + longint'(w.dt));
                  scaled = (longint'($signed(w.value)) - longint'(chan_y[ch])) * gain;
                  // Arithmetic shift of a signed product rounds toward minus infinity.
                  chan_y[ch] = DATA_W'(longint'(chan_y[ch]) + (scaled >>> 16));
               end
            end
         end
         CMD_PRESET_ONE: chan_y[ch] = w.value;
         CMD_PRESET_ALL: begin
            for (int i = 0; i < CHANNELS; i++) begin
               chan_y[i] = w.value;
            end
         end
         default: ;
      endcase
      r.channel = w.channel;
      r.value = chan_y[ch];
      return r;
   endfunction

   function automatic word_type make_word(input cmd_type cmd, input int ch,
                                          input logic [DATA_W-1:0] value,
                                          input logic [DT_W-1:0] dt);
      word_type w;
      w.cmd = cmd;
      w.channel = CH_FIELD_W'(ch);
      w.value = value;
      w.dt = dt;
      return w;
   endfunction

   function automatic word_type random_word();
      word_type w;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         w.cmd = CMD_FILTER;
      end else if (pick < 80) begin
         w.cmd = CMD_PRESET_ONE;
      end else if (pick < 85) begin
         w.cmd = CMD_PRESET_ALL;
      end else begin
         w.cmd = CMD_QUERY;
      end
      w.channel = CH_FIELD_W'($urandom_range(0, CHANNELS - 1));
      // Repeated targets let a channel settle, as a step response would.
      if ($urandom_range(0, 15) == 0) begin
         sweep_target[w.channel] = $urandom();
      end
      case ($urandom_range(0, 7))
         0: w.value = 32'h7FFF_FFFF;
         1: w.value = 32'h8000_0000;
         2: w.value = DATA_W'($signed($urandom_range(0, 511)) - 256);
         3, 4: w.value = sweep_target[w.channel];
         default: w.value = $urandom();
      endcase
      case ($urandom_range(0, 7))
         0: w.dt = '0;
         1: w.dt = 16'hFFFF;
         2: w.dt = 16'd1;
         3: w.dt = DT_W'($urandom_range(1, 100));
         default: w.dt = DT_W'($urandom_range(0, 65535));
      endcase
      return w;
   endfunction

   function automatic logic [TAU_W-1:0] pick_tau();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return BYPASS_TAU;
         2: return TAU_W'(2);
         3: return TAU_W'(1000000);
         4: return '1;
         5: return TAU_W'($urandom_range(2, 2000));
         default: return TAU_W'($urandom_range(0, 20'hFFFFF));
      endcase
   endfunction

   task automatic queue_word(input word_type w);
      pending_words.push_back(w);
      words_queued++;
   endtask

   // Called at a falling edge; keeps csr_valid high across the four writes.
   task automatic write_time_constants(input logic [TAU_REGS-1:0][TAU_W-1:0] taus);
      for (int i = REG_TAU_CH0; i <= REG_TAU_CH3; i++) begin
         csr_index <= CSR_IDX_W'(i);
         csr_data <= taus[i];
         csr_valid <= 1'b1;
         do @(negedge clock); while (!csr_fire);
      end
      csr_valid <= 1'b0;
      tau_settings++;
   endtask

   task automatic drain();
      while (words_accepted != words_queued || expected_outputs.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Input driver.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait <= 0;
      end else if (req_tvalid && !req_fire) begin
         // The word on the bus has not been taken yet.
      end else if (req_wait != 0) begin
         req_tvalid <= 1'b0;
         req_wait <= req_wait - 1;
      end else if (pending_words.size() != 0) begin
         req_tdata <= {pending_words[0].dt, pending_words[0].value};
         req_tuser <= {pending_words[0].channel, pending_words[0].cmd};
         void'(pending_words.pop_front());
         req_tvalid <= 1'b1;
         req_wait <= req_idle_on ? $urandom_range(0, 7) : 0;
         if ($urandom_range(0, 39) == 0) begin
            req_idle_on <= !req_idle_on;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Result receiver.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_hold) begin
         rsp_tready <= 1'b0;
      end else if (rsp_wait != 0) begin
         rsp_tready <= 1'b0;
         rsp_wait <= rsp_wait - 1;
      end else if (rsp_fire && rsp_idle_on) begin
         rsp_draw = $urandom_range(0, 7);
         rsp_tready <= (rsp_draw == 0);
         rsp_wait <= (rsp_draw == 0) ? 0 : rsp_draw - 1;
         if ($urandom_range(0, 39) == 0) begin
            rsp_idle_on <= 1'b0;
         end
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_fire && $urandom_range(0, 39) == 0) begin
            rsp_idle_on <= 1'b1;
         end
      end
   end

   // Long hold-off of the receiver so the core fills up and stalls its input.
   initial begin
      wait (pressure_arm);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   // Prediction and checking.
   always @(posedge clock) begin
      result_type expected;
      word_type   w;
      req_fire <= req_tvalid && req_tready;
      rsp_fire <= rsp_tvalid && rsp_tready;
      csr_fire <= csr_valid && csr_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            tau_model[csr_index] = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outputs.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= MISMATCH_SHOWN) begin
                  $display("Unexpected result word: channel %0d output %h",
                           rsp_tuser, rsp_tdata);
               end
            end else begin
               expected = expected_outputs.pop_front();
               results_checked++;
               if (rsp_tuser !== expected.channel || rsp_tdata !== expected.value) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= MISMATCH_SHOWN) begin
                     $display({"Mismatch on result %0d: channel exp %0d got %0d, ",
                               "output exp %h got %h"},
                              results_checked, expected.channel, rsp_tuser,
                              expected.value, rsp_tdata);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            w.cmd = cmd_type'(req_tuser[1:0]);
            w.channel = req_tuser[3:2];
            w.value = req_tdata[31:0];
            w.dt = req_tdata[47:32];
            expected_outputs.push_back(lowpass_next(w));
            words_accepted++;
            case (w.cmd)
               CMD_FILTER: begin
                  filter_words++;
                  if (w.dt == '0) begin
                     hold_words++;
                  end
               end
               CMD_PRESET_ONE, CMD_PRESET_ALL: preset_words++;
               default: query_words++;
            endcase
         end
      end
   end

   // Watchdog on stretches without any handshake.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", idle_cycles);
         $display("FAIL multichannel_first_order_lowpass_core");
         $finish;
      end
   end

   initial begin
      logic [TAU_REGS-1:0][TAU_W-1:0] taus;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Time constants at their reset value of zero: every channel bypasses.
      queue_word(make_word(CMD_QUERY, 0, 32'h0000_0000, 16'd0));
      queue_word(make_word(CMD_FILTER, 1, 32'h7FFF_FFFF, 16'd100));
      queue_word(make_word(CMD_FILTER, 2, 32'h8000_0000, 16'hFFFF));
      queue_word(make_word(CMD_FILTER, 3, 32'h0000_3039, 16'd0));
      queue_word(make_word(CMD_PRESET_ONE, 0, 32'h1234_5678, 16'd0));
      queue_word(make_word(CMD_FILTER, 0, 32'h0000_0000, 16'd5));
      queue_word(make_word(CMD_PRESET_ALL, 2, 32'hFFFF_FFFF, 16'hFFFF));
      queue_word(make_word(CMD_QUERY, 3, 32'h0000_0000, 16'd0));
      drain();

      // Bypass at tau of one, the smallest filtering tau, and the two large ones.
      write_time_constants({20'hFFFFF, 20'd1000000, 20'd2, 20'd1});
      queue_word(make_word(CMD_FILTER, 0, 32'h0000_0005, 16'd1));
      queue_word(make_word(CMD_PRESET_ONE, 1, 32'h8000_0000, 16'd0));
      queue_word(make_word(CMD_FILTER, 1, 32'h7FFF_FFFF, 16'hFFFF));
      queue_word(make_word(CMD_FILTER, 1, 32'h8000_0000, 16'hFFFF));
      queue_word(make_word(CMD_FILTER, 1, 32'hFFFF_FFFF, 16'd3));
      queue_word(make_word(CMD_PRESET_ONE, 2, 32'h0000_0000, 16'd0));
      queue_word(make_word(CMD_FILTER, 2, 32'h8000_0000, 16'd1000));
      queue_word(make_word(CMD_FILTER, 2, 32'h0000_0001, 16'd0));
      queue_word(make_word(CMD_FILTER, 3, 32'h7FFF_FFFF, 16'hFFFF));
      queue_word(make_word(CMD_FILTER, 3, 32'h7FFF_FFFF, 16'hFFFF));
      queue_word(make_word(CMD_QUERY, 2, 32'h0000_0000, 16'd0));
      queue_word(make_word(CMD_QUERY, 1, 32'hFFFF_FFFF, 16'hFFFF));
      queue_word(make_word(CMD_PRESET_ALL, 3, 32'h7FFF_FFFF, 16'd0));
      queue_word(make_word(CMD_FILTER, 1, 32'h8000_0000, 16'd1));
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int i = 0; i < TAU_REGS; i++) begin
            taus[i] = pick_tau();
         end
         write_time_constants(taus);
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            queue_word(random_word());
         end
         if (p == 0) begin
            pressure_arm = 1'b1;
         end
         drain();
      end

      fail_count = fail_count + expected_outputs.size();
      $display({"Checked %0d results of %0d words: %0d filter (%0d zero step), ",
                "%0d preset, %0d query."},
               results_checked, words_accepted, filter_words, hold_words, preset_words,
               query_words);
      $display("Time constants loaded %0d times; receiver held off once for %0d cycles.",
               tau_settings, HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("PASS multichannel_first_order_lowpass_core");
      end else begin
         $display("FAIL multichannel_first_order_lowpass_core");
      end
      $finish;
   end

endmodule
